>>> rtl/nec_ir_pkg.sv
// ----------------------------------------------------------------------------
// nec_ir_pkg
// Types and constants shared by the NEC infrared edge decoder modules.
// ----------------------------------------------------------------------------
package nec_ir_pkg;

  // Bits in one NEC frame: 16-bit address, command, inverted command.
  localparam int FRAME_BITS = 32;
  localparam int COUNT_BITS = 6;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_INDEX_BITS = 3;

  // Item opcodes. The remaining code is ignored.
  typedef enum logic [1:0] {
    OP_EDGE     = 2'd0,
    OP_CLR_CONT = 2'd1,
    OP_CLR_ALL  = 2'd2
  } op_t;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LEADER_WIN = 3'd0,
    CFG_REPEAT_WIN = 3'd1,
    CFG_BIT_WIN    = 3'd2,
    CFG_GAP_WIN    = 3'd3,
    CFG_REP_LIMIT  = 3'd4,
    CFG_HOLD_THR   = 3'd5
  } cfg_index_t;

  // Decoder phases.
  typedef enum logic [3:0] {
    PH_WAIT        = 4'd0,
    PH_SPACE       = 4'd1,
    PH_MARK        = 4'd2,
    PH_BIT         = 4'd3,
    PH_CHECK       = 4'd4,
    PH_REP_WAIT    = 4'd5,
    PH_REP_MARK    = 4'd6,
    PH_REP_SPACE   = 4'd7,
    PH_REP_CONFIRM = 4'd8
  } phase_t;

  // Programmed configuration.
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] leader_windows;
    logic [CFG_DATA_BITS-1:0] repeat_windows;
    logic [CFG_DATA_BITS-1:0] bit_windows;
    logic [CFG_DATA_BITS-1:0] gap_windows;
    logic [7:0]               repeat_limit;
    logic [7:0]               hold_threshold;
  } cfg_t;

  // Result values carried by each output item.
  typedef struct packed {
    logic        frame_ready;
    logic [15:0] remote_addr;
    logic [7:0]  command;
    logic        press_hold;
    logic        continuing;
  } res_t;

endpackage

>>> rtl/nec_ir_core.sv
// ----------------------------------------------------------------------------
// nec_ir_core
// Edge timing state machine, frame check and result flags of the decoder.
// ----------------------------------------------------------------------------
module nec_ir_core import nec_ir_pkg::*; #(
  parameter int TIME_BITS   = 32,
  parameter int WINDOW_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           op,
  input  logic [TIME_BITS-1:0] now_time,
  input  cfg_t                 cfg,
  output res_t                 res_next
);

  phase_t                phase, phase_next;
  logic [TIME_BITS-1:0]  last_edge_time, last_edge_time_next;
  logic [TIME_BITS-1:0]  last_frame_time, last_frame_time_next;
  logic [FRAME_BITS-1:0] shift_word, shift_word_next;
  logic [FRAME_BITS-1:0] previous_frame, previous_frame_next;
  logic [COUNT_BITS-1:0] bit_count, bit_count_next;
  logic [7:0]            repeat_count, repeat_count_next;
  logic                  recheck_pending, recheck_pending_next;
  res_t                  results;

  logic [TIME_BITS-1:0]  delta, since;
  logic                  win_lead_mark, win_lead_space, win_rep_space, win_rep_delay;
  logic                  win_short, win_long, win_gap_rep, win_gap_frame, gap_glitch;
  logic [COUNT_BITS-1:0] bit_count_inc;
  logic [7:0]            repeat_count_inc;
  logic                  frame_ok;

  // Open window test: strictly between the minimum and the maximum.
  function automatic logic in_win(input logic [TIME_BITS-1:0] d,
                                  input logic [CFG_DATA_BITS-1:0] reg_val,
                                  input logic pair);
    logic [WINDOW_BITS-1:0] wmin;
    logic [WINDOW_BITS-1:0] wmax;
    begin
      wmin = pair ? reg_val[32 +: WINDOW_BITS] : reg_val[0 +: WINDOW_BITS];
      wmax = pair ? reg_val[48 +: WINDOW_BITS] : reg_val[16 +: WINDOW_BITS];
      in_win = (d > TIME_BITS'(wmin)) && (d < TIME_BITS'(wmax));
    end
  endfunction

  // Intervals and window compares, wrapping at the timestamp width.
  assign delta = now_time - last_edge_time;
  assign since = now_time - last_frame_time;

  assign win_lead_mark  = in_win(delta, cfg.leader_windows, 1'b0);
  assign win_lead_space = in_win(delta, cfg.leader_windows, 1'b1);
  assign win_rep_space  = in_win(delta, cfg.repeat_windows, 1'b0);
  assign win_rep_delay  = in_win(since, cfg.repeat_windows, 1'b1);
  assign win_short      = in_win(delta, cfg.bit_windows, 1'b0);
  assign win_long       = in_win(delta, cfg.bit_windows, 1'b1);
  assign win_gap_rep    = in_win(delta, cfg.gap_windows, 1'b0);
  assign win_gap_frame  = in_win(delta, cfg.gap_windows, 1'b1);
  assign gap_glitch     = delta < TIME_BITS'(cfg.gap_windows[32 +: WINDOW_BITS]);

  assign bit_count_inc    = bit_count + COUNT_BITS'(1);
  assign repeat_count_inc = repeat_count + 8'd1;

  // Command byte must be the bitwise inverse of its check byte.
  assign frame_ok = (shift_word[23:16] ^ shift_word[31:24]) == 8'hFF;

  // Next phase.
  always_comb begin
    phase_next = phase;
    if (op_t'(op) == OP_EDGE) begin
      case (phase)
        PH_WAIT: begin
          if (win_lead_mark) phase_next = PH_SPACE;
        end
        PH_SPACE: begin
          if (win_lead_space) phase_next = PH_MARK;
          else if (win_rep_space && win_rep_delay) phase_next = PH_REP_CONFIRM;
          else phase_next = PH_WAIT;
        end
        PH_MARK: begin
          phase_next = win_short ? PH_BIT : PH_WAIT;
        end
        PH_BIT: begin
          if (win_short || win_long) begin
            phase_next = (bit_count_inc == COUNT_BITS'(FRAME_BITS)) ? PH_CHECK : PH_MARK;
          end else begin
            phase_next = PH_WAIT;
          end
        end
        PH_CHECK: phase_next = PH_WAIT;
        PH_REP_WAIT: begin
          if (repeat_count < cfg.repeat_limit && win_gap_rep) begin
            phase_next = PH_REP_MARK;
          end else if (repeat_count == cfg.repeat_limit && win_gap_frame) begin
            phase_next = PH_WAIT;
          end else if (!gap_glitch) begin
            phase_next = PH_WAIT;
          end
        end
        PH_REP_MARK: phase_next = win_lead_mark ? PH_REP_SPACE : PH_WAIT;
        PH_REP_SPACE: phase_next = win_rep_space ? PH_REP_CONFIRM : PH_WAIT;
        PH_REP_CONFIRM: phase_next = PH_REP_WAIT;
        default: phase_next = PH_WAIT;
      endcase
    end
  end

  // Timestamps, shift word, counters and result flags.
  always_comb begin
    last_edge_time_next  = last_edge_time;
    last_frame_time_next = last_frame_time;
    shift_word_next      = shift_word;
    previous_frame_next  = previous_frame;
    bit_count_next       = bit_count;
    repeat_count_next    = repeat_count;
    recheck_pending_next = recheck_pending;
    res_next             = results;
    case (op_t'(op))
      OP_EDGE: begin
        case (phase)
          PH_WAIT: last_edge_time_next = now_time;
          PH_SPACE: begin
            if (win_lead_space) begin
              last_edge_time_next = now_time;
              bit_count_next      = '0;
              res_next.continuing = 1'b1;
            end else if (win_rep_space && win_rep_delay) begin
              repeat_count_next = '0;
            end
          end
          PH_MARK: begin
            if (win_short) last_edge_time_next = now_time;
          end
          PH_BIT: begin
            if (win_short || win_long) begin
              last_edge_time_next = now_time;
              shift_word_next     = {!win_short, shift_word[FRAME_BITS-1:1]};
              bit_count_next      = bit_count_inc;
            end
          end
          PH_CHECK: begin
            if (!recheck_pending) begin
              if (frame_ok) begin
                last_frame_time_next = last_edge_time;
                res_next.frame_ready = 1'b1;
                res_next.remote_addr = shift_word[15:0];
                res_next.command     = shift_word[23:16];
                res_next.continuing  = 1'b1;
              end
              previous_frame_next = shift_word;
            end else begin
              if (shift_word == previous_frame) begin
                last_frame_time_next = last_edge_time;
                res_next.continuing  = 1'b1;
              end
              recheck_pending_next = 1'b0;
            end
          end
          PH_REP_WAIT: begin
            if (repeat_count < cfg.repeat_limit && win_gap_rep) begin
              last_edge_time_next = now_time;
            end else if (repeat_count == cfg.repeat_limit && win_gap_frame) begin
              last_edge_time_next  = now_time;
              recheck_pending_next = 1'b1;
            end else if (!gap_glitch) begin
              last_edge_time_next = now_time;
            end
          end
          PH_REP_MARK: begin
            if (win_lead_mark) last_edge_time_next = now_time;
          end
          PH_REP_CONFIRM: begin
            last_edge_time_next = now_time;
            repeat_count_next   = repeat_count_inc;
            if (repeat_count_inc == cfg.hold_threshold) res_next.press_hold = 1'b1;
            res_next.continuing = 1'b1;
          end
          default: ;
        endcase
      end
      OP_CLR_CONT: res_next.continuing = 1'b0;
      OP_CLR_ALL:  res_next = '0;
      default: ;
    endcase
  end

  // State registers, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_WAIT;
      last_edge_time  <= '0;
      last_frame_time <= '0;
      shift_word      <= '0;
      previous_frame  <= '0;
      bit_count       <= '0;
      repeat_count    <= '0;
      recheck_pending <= 1'b0;
      results         <= '0;
    end else if (step) begin
      phase           <= phase_next;
      last_edge_time  <= last_edge_time_next;
      last_frame_time <= last_frame_time_next;
      shift_word      <= shift_word_next;
      previous_frame  <= previous_frame_next;
      bit_count       <= bit_count_next;
      repeat_count    <= repeat_count_next;
      recheck_pending <= recheck_pending_next;
      results         <= res_next;
    end
  end

endmodule

>>> rtl/nec_ir_edge_decoder_unit.sv
// An accepted item waits in the input register, its result in the result register.
// Throughput: one item per cycle while the receiver takes results; the whole state
// update is one pass of logic between the input register and the result register.
// Reset (synchronous, active high) returns the decoder to waiting for a leader
// mark, clears all timestamps, counters and results, and all configuration.
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_unit
// NEC infrared decoder driven by edge timestamps, with repeat and hold tracking.
// ----------------------------------------------------------------------------
module nec_ir_edge_decoder_unit import nec_ir_pkg::*; #(
  parameter int TIME_BITS   = 32,
  parameter int WINDOW_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                opcode,
  input  logic [31:0]               edge_time,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      frame_ready,
  output logic [15:0]               remote_addr,
  output logic [7:0]                command,
  output logic                      press_hold,
  output logic                      continuing
);

  cfg_t                 cfg;
  logic                 item_valid;
  logic [1:0]           item_op;
  logic [TIME_BITS-1:0] item_time;
  logic                 advance;
  res_t                 res_next;
  res_t                 res_out;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index_t'(cfg_index))
        CFG_LEADER_WIN: cfg.leader_windows <= cfg_data;
        CFG_REPEAT_WIN: cfg.repeat_windows <= cfg_data;
        CFG_BIT_WIN:    cfg.bit_windows    <= cfg_data;
        CFG_GAP_WIN:    cfg.gap_windows    <= cfg_data;
        CFG_REP_LIMIT:  cfg.repeat_limit   <= cfg_data[7:0];
        CFG_HOLD_THR:   cfg.hold_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // An item moves on when the result register is free or being emptied.
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_op   <= opcode;
      item_time <= TIME_BITS'(edge_time);
    end
  end

  nec_ir_core #(
    .TIME_BITS   (TIME_BITS),
    .WINDOW_BITS (WINDOW_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .step     (advance),
    .op       (item_op),
    .now_time (item_time),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_out <= res_next;
    end
  end

  assign frame_ready = res_out.frame_ready;
  assign remote_addr = res_out.remote_addr;
  assign command     = res_out.command;
  assign press_hold  = res_out.press_hold;
  assign continuing  = res_out.continuing;

endmodule

>>> sim/nec_ir_edge_decoder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nec_ir_edge_decoder_unit_tb
// Self-checking bench for the NEC edge decoder. A short table of edges and
// clear items comes first, then framed NEC bursts with repeats and recheck
// frames, mixed with noise, under six register settings. Every result item is
// compared with the table's value or a cycle-free model of the decoder in the bench.
// ----------------------------------------------------------------------------
module nec_ir_edge_decoder_unit_tb;
  import nec_ir_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int STALL_CYCLES = 300;
  localparam int DIR_ROWS     = 21;
  localparam int DIR_CFG_ROW  = 7;

  // The fourth opcode has no meaning and must leave the results untouched.
  localparam logic [1:0] OP_IGNORED = 2'd3;

  // Window registers: {max B, min B, max A, min A}, 16 bits each.
  localparam logic [63:0] LEADER_NOM = {16'd50, 16'd40, 16'd100, 16'd80};
  localparam logic [63:0] REPEAT_NOM = {16'd900, 16'd400, 16'd27, 16'd18};
  localparam logic [63:0] BIT_NOM    = {16'd20, 16'd14, 16'd8, 16'd3};
  localparam logic [63:0] GAP_NOM    = {16'd1300, 16'd1100, 16'd1000, 16'd900};
  localparam logic [63:0] WIN_WIDE   = {16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
  localparam logic [63:0] WIN_SHUT   = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam res_t NO_RESULT = '0;
  localparam res_t CONT_ONLY = '{frame_ready: 1'b0, remote_addr: 16'h0, command: 8'h0,
                                 press_hold: 1'b0, continuing: 1'b1};

  typedef struct {
    logic [1:0]  op;
    logic [31:0] stamp;
    bit          typed;
    res_t        want;
  } dir_row_t;

  // Directed rows: reset settings first, then the nominal windows.
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_EDGE,     32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'hFFFF_FFFF, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'h7FFF_FFFF, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'h8000_0000, 1'b1, NO_RESULT},
    '{OP_CLR_CONT, 32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_CLR_ALL,  32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_IGNORED,  32'hFFFF_FFFF, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'd1000,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1090,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1135,      1'b1, CONT_ONLY},
    '{OP_CLR_CONT, 32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_IGNORED,  32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'd1140,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1300,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1390,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1480,      1'b0, NO_RESULT},
    '{OP_EDGE,     32'd1502,      1'b0, NO_RESULT},
    '{OP_CLR_ALL,  32'h0000_0000, 1'b1, NO_RESULT},
    '{OP_EDGE,     32'hFFFF_FFF0, 1'b0, NO_RESULT},
    '{OP_EDGE,     32'h0000_0050, 1'b0, NO_RESULT},
    '{OP_EDGE,     32'h0000_007D, 1'b0, NO_RESULT}
  };

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [1:0]                opcode = OP_EDGE;
  logic [31:0]               edge_time = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic                      frame_ready;
  logic [15:0]               remote_addr;
  logic [7:0]                command;
  logic                      press_hold;
  logic                      continuing;

  // Model of the decoder, reset values as after rst.
  cfg_t        shadow_cfg = '0;
  phase_t      dec_phase = PH_WAIT;
  logic [31:0] mark_time = '0;
  logic [31:0] frame_time = '0;
  logic [31:0] rx_word = '0;
  logic [31:0] held_word = '0;
  logic [5:0]  rx_bits = '0;
  logic [7:0]  repeat_cnt = '0;
  logic        recheck_due = 1'b0;
  res_t        shown = '0;

  res_t        pending_results [$];
  res_t        head_result;
  int          error_count = 0;
  int          cycle_count = 0;
  int          sent_count = 0;
  bit          idle_on = 1'b1;
  int          spoil_pct = 2;
  int          stall_token = 0;
  int          stall_seen = 0;
  int          stall_left = 0;
  logic [31:0] t_now = '0;
  logic [31:0] last_bit_t = '0;

  nec_ir_edge_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .edge_time   (edge_time),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .frame_ready (frame_ready),
    .remote_addr (remote_addr),
    .command     (command),
    .press_hold  (press_hold),
    .continuing  (continuing)
  );

  always #10 clk = ~clk;

  // Run limit, in case the decoder stops answering.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("FAIL nec_ir_edge_decoder_unit");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_token != stall_seen) begin
      stall_seen <= stall_token;
      stall_left <= STALL_CYCLES;
      out_ready <= 1'b0;
    end else if (idle_on) begin
      out_ready <= ($urandom_range(99) >= 31);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each result item with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected result item: ready=%0d id=%h cmd=%h hold=%0d cont=%0d",
                   frame_ready, remote_addr, command, press_hold, continuing);
      end else begin
        head_result = pending_results.pop_front();
        if (frame_ready !== head_result.frame_ready ||
            remote_addr !== head_result.remote_addr ||
            command !== head_result.command || press_hold !== head_result.press_hold ||
            continuing !== head_result.continuing) begin
          error_count++;
          if (error_count <= 10) begin
            $display("mismatch: expected ready=%0d id=%h cmd=%h hold=%0d cont=%0d",
                     head_result.frame_ready, head_result.remote_addr, head_result.command,
                     head_result.press_hold, head_result.continuing);
            $display("          got      ready=%0d id=%h cmd=%h hold=%0d cont=%0d",
                     frame_ready, remote_addr, command, press_hold, continuing);
          end
        end
      end
    end
  end

  // Open window test: min < d < max on the chosen pair.
  function automatic logic win_hit(input logic [31:0] d, input logic [63:0] w, input int pair);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = w[pair*32 +: 16];
    hi = w[pair*32+16 +: 16];
    return (d > {16'd0, lo}) && (d < {16'd0, hi});
  endfunction

  // One edge through the decoder model.
  function automatic void step_decoder(input logic [31:0] now);
    logic [31:0] d;
    logic [31:0] since;
    logic        one_bit;
    d = now - mark_time;
    case (dec_phase)
      PH_WAIT: begin
        if (win_hit(d, shadow_cfg.leader_windows, 0)) dec_phase = PH_SPACE;
        mark_time = now;
      end
      PH_SPACE: begin
        if (win_hit(d, shadow_cfg.leader_windows, 1)) begin
          mark_time = now;
          rx_bits = '0;
          shown.continuing = 1'b1;
          dec_phase = PH_MARK;
        end else if (win_hit(d, shadow_cfg.repeat_windows, 0)) begin
          // A repeat code only counts soon enough after the last good frame.
          since = now - frame_time;
          if (win_hit(since, shadow_cfg.repeat_windows, 1)) begin
            dec_phase = PH_REP_CONFIRM;
            repeat_cnt = '0;
          end else begin
            dec_phase = PH_WAIT;
          end
        end else begin
          dec_phase = PH_WAIT;
        end
      end
      PH_MARK: begin
        if (win_hit(d, shadow_cfg.bit_windows, 0)) begin
          mark_time = now;
          dec_phase = PH_BIT;
        end else begin
          dec_phase = PH_WAIT;
        end
      end
      PH_BIT: begin
        if (win_hit(d, shadow_cfg.bit_windows, 0) || win_hit(d, shadow_cfg.bit_windows, 1)) begin
          one_bit = !win_hit(d, shadow_cfg.bit_windows, 0);
          mark_time = now;
          rx_word = {one_bit, rx_word[31:1]};
          rx_bits = rx_bits + 6'd1;
          dec_phase = (rx_bits == FRAME_BITS) ? PH_CHECK : PH_MARK;
        end else begin
          dec_phase = PH_WAIT;
        end
      end
      PH_CHECK: begin
        // The stop edge is taken without timing; the frame is judged here.
        if (!recheck_due) begin
          if ((rx_word[31:24] ^ rx_word[23:16]) == 8'hFF) begin
            frame_time = mark_time;
            shown.frame_ready = 1'b1;
            shown.remote_addr = rx_word[15:0];
            shown.command = rx_word[23:16];
            shown.continuing = 1'b1;
          end
          held_word = rx_word;
        end else begin
          if (rx_word == held_word) begin
            frame_time = mark_time;
            shown.continuing = 1'b1;
          end
          recheck_due = 1'b0;
        end
        dec_phase = PH_WAIT;
      end
      PH_REP_WAIT: begin
        if (repeat_cnt < shadow_cfg.repeat_limit && win_hit(d, shadow_cfg.gap_windows, 0)) begin
          mark_time = now;
          dec_phase = PH_REP_MARK;
        end else if (repeat_cnt == shadow_cfg.repeat_limit &&
                     win_hit(d, shadow_cfg.gap_windows, 1)) begin
          mark_time = now;
          recheck_due = 1'b1;
          dec_phase = PH_WAIT;
        end else if (d < {16'd0, shadow_cfg.gap_windows[47:32]}) begin
          // Short glitch: nothing changes.
        end else begin
          mark_time = now;
          dec_phase = PH_WAIT;
        end
      end
      PH_REP_MARK: begin
        if (win_hit(d, shadow_cfg.leader_windows, 0)) begin
          mark_time = now;
          dec_phase = PH_REP_SPACE;
        end else begin
          dec_phase = PH_WAIT;
        end
      end
      PH_REP_SPACE: begin
        dec_phase = win_hit(d, shadow_cfg.repeat_windows, 0) ? PH_REP_CONFIRM : PH_WAIT;
      end
      PH_REP_CONFIRM: begin
        mark_time = now;
        repeat_cnt = repeat_cnt + 8'd1;
        if (repeat_cnt == shadow_cfg.hold_threshold) shown.press_hold = 1'b1;
        shown.continuing = 1'b1;
        dec_phase = PH_REP_WAIT;
      end
      default: dec_phase = PH_WAIT;
    endcase
  endfunction

  // Result values after one input item.
  function automatic res_t predict_item(input logic [1:0] op, input logic [31:0] stamp);
    case (op)
      OP_EDGE:     step_decoder(stamp);
      OP_CLR_CONT: shown.continuing = 1'b0;
      OP_CLR_ALL:  shown = '0;
      default:     ;
    endcase
    return shown;
  endfunction

  // Offer one item, wait for its handshake and record what should come back.
  task automatic offer(input logic [1:0] op, input logic [31:0] stamp, input bit typed,
                       input res_t want);
    res_t model_res;
    while (idle_on && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    edge_time <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    model_res = predict_item(op, stamp);
    pending_results.push_back(typed ? want : model_res);
    if (op != OP_IGNORED) sent_count++;
  endtask

  task automatic push_item(input logic [1:0] op, input logic [31:0] stamp);
    offer(op, stamp, 1'b0, NO_RESULT);
  endtask

  // Register write; cfg_valid is lowered by the caller after the last one.
  task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_LEADER_WIN: shadow_cfg.leader_windows = val;
      CFG_REPEAT_WIN: shadow_cfg.repeat_windows = val;
      CFG_BIT_WIN:    shadow_cfg.bit_windows = val;
      CFG_GAP_WIN:    shadow_cfg.gap_windows = val;
      CFG_REP_LIMIT:  shadow_cfg.repeat_limit = val[7:0];
      CFG_HOLD_THR:   shadow_cfg.hold_threshold = val[7:0];
      default:        ;
    endcase
  endtask

  // Let every result drain, then program all six registers.
  task automatic reconfigure(input logic [63:0] lead, input logic [63:0] rep,
                             input logic [63:0] bits, input logic [63:0] gaps,
                             input logic [7:0] limit, input logic [7:0] hold);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    write_reg(CFG_LEADER_WIN, lead);
    write_reg(CFG_REPEAT_WIN, rep);
    write_reg(CFG_BIT_WIN, bits);
    write_reg(CFG_GAP_WIN, gaps);
    write_reg(CFG_REP_LIMIT, {56'd0, limit});
    write_reg(CFG_HOLD_THR, {56'd0, hold});
    cfg_valid <= 1'b0;
  endtask

  // Interval inside a window, or now and then (or for a shut window) anything.
  function automatic logic [31:0] pick_in(input logic [63:0] w, input int pair);
    int unsigned lo;
    int unsigned hi;
    lo = w[pair*32 +: 16];
    hi = w[pair*32+16 +: 16];
    if (hi > lo + 1 && $urandom_range(99) >= spoil_pct) return $urandom_range(hi - 1, lo + 1);
    return $urandom_range(2000, 0);
  endfunction

  // Next edge after an interval, sometimes preceded by a clear or ignored item.
  task automatic emit_edge(input logic [31:0] d);
    int k;
    if ($urandom_range(99) < 3) begin
      k = $urandom_range(99);
      push_item((k < 60) ? OP_CLR_CONT : (k < 85) ? OP_CLR_ALL : OP_IGNORED, $urandom);
    end
    t_now = t_now + d;
    push_item(OP_EDGE, t_now);
  endtask

  // Leader, 32 bits LSB first and the stop edge.
  task automatic send_frame(input logic [31:0] code, input bit lead_in);
    if (lead_in) emit_edge($urandom_range(3000, 1));
    emit_edge(pick_in(shadow_cfg.leader_windows, 0));
    emit_edge(pick_in(shadow_cfg.leader_windows, 1));
    for (int i = 0; i < FRAME_BITS; i++) begin
      emit_edge(pick_in(shadow_cfg.bit_windows, 0));
      emit_edge(pick_in(shadow_cfg.bit_windows, code[i] ? 1 : 0));
    end
    last_bit_t = t_now;
    emit_edge(pick_in(shadow_cfg.bit_windows, 0));
  endtask

  // Repeat code; the first one is timed from the end of the frame.
  task automatic send_repeat(input bit after_frame);
    logic [31:0] m;
    logic [31:0] s;
    logic [31:0] lead_gap;
    m = pick_in(shadow_cfg.leader_windows, 0);
    s = pick_in(shadow_cfg.repeat_windows, 0);
    if (after_frame) begin
      lead_gap = last_bit_t + pick_in(shadow_cfg.repeat_windows, 1) - s - m - t_now;
      if (lead_gap == 0 || lead_gap[31]) lead_gap = $urandom_range(500, 1);
    end else begin
      lead_gap = pick_in(shadow_cfg.gap_windows, 0);
    end
    emit_edge(lead_gap);
    emit_edge(m);
    emit_edge(s);
    emit_edge($urandom_range(20, 1));
  endtask

  // Random traffic: mostly full key presses, some noise and clears.
  task automatic run_phase(input int budget, input bit idle, input bit with_stall,
                           input int spoil);
    logic [31:0] code;
    logic [31:0] stamp;
    logic [1:0]  op;
    int          nrep;
    int          reps_max;
    int          pick;
    bit          stalled;
    idle_on = idle;
    spoil_pct = spoil;
    sent_count = 0;
    stalled = 1'b0;
    while (sent_count < budget) begin
      if (with_stall && !stalled && sent_count >= 20) begin
        stall_token++;
        stalled = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 65) begin
        code = $urandom;
        if ($urandom_range(99) < 75) code[31:24] = ~code[23:16];
        send_frame(code, 1'b1);
        reps_max = (shadow_cfg.repeat_limit < 5) ? shadow_cfg.repeat_limit + 1 : 6;
        if (shadow_cfg.repeat_limit <= 5 && $urandom_range(1) == 1)
          nrep = shadow_cfg.repeat_limit;
        else
          nrep = $urandom_range(reps_max, 0);
        for (int r = 0; r < nrep; r++) send_repeat(r == 0);
        // Recheck frame after the repeats, usually the same code again.
        if (nrep > 0 && $urandom_range(99) < 70) begin
          emit_edge(pick_in(shadow_cfg.gap_windows, 1));
          send_frame(($urandom_range(99) < 75) ? code : $urandom, 1'b0);
        end
      end else if (pick < 85) begin
        for (int n = $urandom_range(6, 1); n > 0; n--) begin
          op = $urandom_range(3, 0);
          stamp = ($urandom_range(1) == 1) ? $urandom : t_now + $urandom_range(200, 0);
          push_item(op, stamp);
          if (op == OP_EDGE) t_now = stamp;
        end
      end else begin
        push_item(($urandom_range(1) == 1) ? OP_CLR_ALL : OP_CLR_CONT, $urandom);
      end
    end
  endtask

  // Main sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed table, with the nominal windows programmed part way.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_CFG_ROW) reconfigure(LEADER_NOM, REPEAT_NOM, BIT_NOM, GAP_NOM, 8'd1, 8'd1);
      offer(dir_rows[i].op, dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].want);
    end

    reconfigure(LEADER_NOM, REPEAT_NOM, BIT_NOM, GAP_NOM, 8'd3, 8'd2);
    run_phase(450, 1'b1, 1'b0, 2);

    // No idling on either side for this whole stretch.
    reconfigure(LEADER_NOM, REPEAT_NOM, BIT_NOM, GAP_NOM, 8'd0, 8'd0);
    run_phase(400, 1'b0, 1'b0, 2);

    // Timestamps cross the wrap point; the receiver holds off once.
    reconfigure(LEADER_NOM, REPEAT_NOM, BIT_NOM, GAP_NOM, 8'd1, 8'd1);
    t_now = 32'hFFFF_F000;
    run_phase(400, 1'b1, 1'b1, 2);

    reconfigure(WIN_WIDE, WIN_WIDE, WIN_WIDE, WIN_WIDE, 8'd255, 8'd255);
    run_phase(300, 1'b1, 1'b0, 2);

    reconfigure(WIN_SHUT, WIN_SHUT, WIN_SHUT, WIN_SHUT, 8'd255, 8'd0);
    run_phase(150, 1'b1, 1'b0, 2);

    reconfigure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                {$urandom, $urandom}, $urandom_range(255, 0), $urandom_range(255, 0));
    run_phase(250, 1'b1, 1'b0, 5);

    // Drain, then allow the pipeline a little longer for stray items.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("PASS nec_ir_edge_decoder_unit");
    else
      $display("FAIL nec_ir_edge_decoder_unit");
    $finish;
  end

endmodule
